// File: sv/bounded_queue_with_max_core_macros.svh
// Assertion macros shared by the bounded queue with maximum.
// Depends on nothing; included by modules that carry assertions.
`ifndef BOUNDED_QUEUE_WITH_MAX_CORE_MACROS_SVH
`define BOUNDED_QUEUE_WITH_MAX_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BQM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BQM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bqm_pkg.sv
// Package for the bounded queue with maximum: widths, codes and state type.
// Depends on nothing; used by the core and its memory.
`default_nettype none

package bqm_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CAP_RESET = 64;
  localparam int DATA_W = 32;
  localparam int CAP_W = 7;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

// File: sv/bqm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on bqm_pkg for its default widths; holds the queue entries of the core.
`default_nettype none

module bqm_ram #(
  parameter int WIDTH = bqm_pkg::DATA_W,
  parameter int DEPTH = bqm_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/bounded_queue_with_max_core.sv
// Enqueue and query raise done in the cycle after accept; dequeue passes through ST_DEQ first.
// A dequeue that removes the maximum while a runner-up exists promotes it and
// rescans the entries behind it through the one memory read port: busy stays
// high in ST_SCAN until every one of those entries has been read.
// The receiver cannot stall. Synchronous reset empties the queue and sets the
// capacity to 64 (or DEPTH if smaller); memory contents are not cleared.
`default_nettype none

module bounded_queue_with_max_core #(
  parameter int DEPTH = bqm_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [bqm_pkg::OP_W-1:0]     opcode,
  input  wire logic signed [bqm_pkg::DATA_W-1:0]   value_in,
  output logic                                     done,
  output logic             [bqm_pkg::STATUS_W-1:0] status,
  output logic signed      [bqm_pkg::DATA_W-1:0]   value_out,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [bqm_pkg::CAP_W-1:0]    capacity
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int XW0 = (FW > IW + 1) ? FW : IW + 1;
  localparam int XW = (XW0 > bqm_pkg::CAP_W) ? XW0 : bqm_pkg::CAP_W;

  bqm_pkg::state_t state, state_next;

  logic [bqm_pkg::CAP_W-1:0] cap_limit, cap_limit_next;
  logic [IW-1:0] head_index, head_index_next;
  logic [IW-1:0] tail_index, tail_index_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic signed [bqm_pkg::DATA_W-1:0] max_value, max_value_next;
  logic [IW-1:0] max_slot, max_slot_next;
  logic signed [bqm_pkg::DATA_W-1:0] runner_value, runner_value_next;
  logic [IW-1:0] runner_slot, runner_slot_next;
  logic runner_valid, runner_valid_next;
  logic [IW-1:0] deq_slot, deq_slot_next;
  logic [IW-1:0] scan_addr, scan_addr_next;
  logic pend, pend_next;
  logic [IW-1:0] pend_slot, pend_slot_next;
  logic done_next;
  logic [bqm_pkg::STATUS_W-1:0] status_next;
  logic signed [bqm_pkg::DATA_W-1:0] value_out_next;

  logic ram_wr_en;
  logic ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  logic [bqm_pkg::DATA_W-1:0] ram_rd_data;
  logic [bqm_pkg::CAP_W-1:0] cap_clamped;

  function automatic logic [IW-1:0] slot_after(input logic [IW-1:0] i,
                                               input logic [bqm_pkg::CAP_W-1:0] cap);
    logic [XW-1:0] n;
    n = XW'(i) + XW'(1);
    if (n >= XW'(cap) || n >= XW'(DEPTH)) begin
      slot_after = '0;
    end else begin
      slot_after = IW'(n);
    end
  endfunction

  bqm_ram #(
    .WIDTH(bqm_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(tail_index),
    .wr_data(value_in),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign busy = (state != bqm_pkg::ST_IDLE);
  assign cfg_ready = (state == bqm_pkg::ST_IDLE) && !start;

  always_comb begin
    if (capacity == '0) begin
      cap_clamped = bqm_pkg::CAP_W'(1);
    end else if (XW'(capacity) > XW'(DEPTH)) begin
      cap_clamped = bqm_pkg::CAP_W'(DEPTH);
    end else begin
      cap_clamped = capacity;
    end
  end

  always_comb begin
    state_next = state;
    cap_limit_next = cap_limit;
    head_index_next = head_index;
    tail_index_next = tail_index;
    fill_count_next = fill_count;
    max_value_next = max_value;
    max_slot_next = max_slot;
    runner_value_next = runner_value;
    runner_slot_next = runner_slot;
    runner_valid_next = runner_valid;
    deq_slot_next = deq_slot;
    scan_addr_next = scan_addr;
    pend_next = pend;
    pend_slot_next = pend_slot;
    done_next = 1'b0;
    status_next = status;
    value_out_next = value_out;
    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    ram_rd_addr = head_index;

    unique case (state)
      bqm_pkg::ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          status_next = bqm_pkg::STATUS_OK;
          value_out_next = '0;
          unique case (opcode)
            bqm_pkg::OP_ENQUEUE: begin
              if (XW'(fill_count) >= XW'(cap_limit)) begin
                status_next = bqm_pkg::STATUS_FULL;
              end else begin
                ram_wr_en = 1'b1;
                if (fill_count == '0 || value_in > max_value) begin
                  max_value_next = value_in;
                  max_slot_next = tail_index;
                  runner_valid_next = 1'b0;
                  runner_value_next = bqm_pkg::MOST_NEG;
                  runner_slot_next = '0;
                end else if (!runner_valid || value_in > runner_value) begin
                  runner_valid_next = 1'b1;
                  runner_value_next = value_in;
                  runner_slot_next = tail_index;
                end
                tail_index_next = slot_after(tail_index, cap_limit);
                fill_count_next = fill_count + FW'(1);
              end
            end
            bqm_pkg::OP_DEQUEUE: begin
              if (fill_count == '0) begin
                status_next = bqm_pkg::STATUS_EMPTY;
              end else begin
                ram_rd_en = 1'b1;
                deq_slot_next = head_index;
                head_index_next = slot_after(head_index, cap_limit);
                fill_count_next = fill_count - FW'(1);
                done_next = 1'b0;
                state_next = bqm_pkg::ST_DEQ;
              end
            end
            bqm_pkg::OP_QUERY: begin
              if (fill_count == '0) begin
                status_next = bqm_pkg::STATUS_EMPTY;
              end else begin
                value_out_next = max_value;
              end
            end
            default: begin
            end
          endcase
        end else if (cfg_valid && fill_count == '0) begin
          cap_limit_next = cap_clamped;
          head_index_next = '0;
          tail_index_next = '0;
          runner_valid_next = 1'b0;
        end
      end
      bqm_pkg::ST_DEQ: begin
        done_next = 1'b1;
        status_next = bqm_pkg::STATUS_OK;
        value_out_next = $signed(ram_rd_data);
        state_next = bqm_pkg::ST_IDLE;
        if (deq_slot == max_slot) begin
          runner_valid_next = 1'b0;
          runner_value_next = bqm_pkg::MOST_NEG;
          runner_slot_next = '0;
          if (runner_valid && fill_count != '0) begin
            max_value_next = runner_value;
            max_slot_next = runner_slot;
            scan_addr_next = slot_after(runner_slot, cap_limit);
            pend_next = 1'b0;
            state_next = bqm_pkg::ST_SCAN;
          end else begin
            max_value_next = bqm_pkg::MOST_NEG;
            max_slot_next = '0;
          end
        end
      end
      bqm_pkg::ST_SCAN: begin
        if (pend && (!runner_valid || $signed(ram_rd_data) > runner_value)) begin
          runner_valid_next = 1'b1;
          runner_value_next = $signed(ram_rd_data);
          runner_slot_next = pend_slot;
        end
        if (scan_addr != tail_index) begin
          ram_rd_en = 1'b1;
          ram_rd_addr = scan_addr;
          pend_next = 1'b1;
          pend_slot_next = scan_addr;
          scan_addr_next = slot_after(scan_addr, cap_limit);
        end else begin
          pend_next = 1'b0;
          state_next = bqm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bqm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqm_pkg::ST_IDLE;
      cap_limit <= (DEPTH < bqm_pkg::CAP_RESET) ? bqm_pkg::CAP_W'(DEPTH)
                                                : bqm_pkg::CAP_W'(bqm_pkg::CAP_RESET);
      head_index <= '0;
      tail_index <= '0;
      fill_count <= '0;
      max_value <= bqm_pkg::MOST_NEG;
      max_slot <= '0;
      runner_value <= bqm_pkg::MOST_NEG;
      runner_slot <= '0;
      runner_valid <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cap_limit <= cap_limit_next;
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      fill_count <= fill_count_next;
      max_value <= max_value_next;
      max_slot <= max_slot_next;
      runner_value <= runner_value_next;
      runner_slot <= runner_slot_next;
      runner_valid <= runner_valid_next;
      pend <= pend_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    deq_slot <= deq_slot_next;
    scan_addr <= scan_addr_next;
    pend_slot <= pend_slot_next;
    status <= status_next;
    value_out <= value_out_next;
  end

`include "bounded_queue_with_max_core_macros.svh"

  `BQM_ASSERT_NOW(a_fill_in_bounds, clk, rst, 1'b1, XW'(fill_count) <= XW'(cap_limit), "fill count exceeds capacity")
  `BQM_ASSERT_NOW(a_no_rw_overlap, clk, rst, ram_wr_en, !ram_rd_en, "memory read and write in the same cycle")
  `BQM_ASSERT_NEXT(a_deq_latency, clk, rst, start && !busy && opcode == bqm_pkg::OP_DEQUEUE && fill_count != '0, !done ##1 done, "dequeue result not two cycles after accept")
  `BQM_ASSERT_NOW(a_runner_apart, clk, rst, runner_valid && fill_count != '0, runner_slot != max_slot, "runner-up shares the slot of the maximum")

endmodule

`default_nettype wire

// File: tb/bounded_queue_with_max_core_test.sv
// Self-checking testbench for bounded_queue_with_max_core: a queue-driven driver,
// a monitor with a software copy of the max queue, and capacity phases.
// Depends on bqm_pkg and the bounded_queue_with_max_core RTL.
`timescale 1ns / 100ps

module bounded_queue_with_max_core_test;

  localparam int DEPTH = bqm_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_OPS = 900;
  localparam logic [bqm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum { REQ_OP, REQ_CFG, REQ_HOLD } req_kind_t;

  typedef struct {
    req_kind_t kind;
    logic [bqm_pkg::OP_W-1:0] op;
    logic signed [bqm_pkg::DATA_W-1:0] val;
    logic [bqm_pkg::CAP_W-1:0] cap;
    int gap;
  } req_t;

  typedef struct packed {
    logic [bqm_pkg::STATUS_W-1:0] status;
    logic signed [bqm_pkg::DATA_W-1:0] value;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [bqm_pkg::OP_W-1:0] opcode = '0;
  logic signed [bqm_pkg::DATA_W-1:0] value_in = '0;
  logic cfg_valid = 1'b0;
  logic [bqm_pkg::CAP_W-1:0] capacity = '0;
  logic busy;
  logic done;
  logic cfg_ready;
  logic [bqm_pkg::STATUS_W-1:0] status;
  logic signed [bqm_pkg::DATA_W-1:0] value_out;

  req_t req_q[$];
  resp_t expected_resp[$];
  int errors = 0;
  int cycles = 0;

  // Software copy of the queue and its maximum tracking.
  logic signed [bqm_pkg::DATA_W-1:0] mem_m [DEPTH];
  logic [5:0] head_m, tail_m, max_slot_m, run_slot_m;
  logic [bqm_pkg::CAP_W-1:0] fill_m, cap_m;
  logic signed [bqm_pkg::DATA_W-1:0] max_val_m, run_val_m;
  logic run_ok_m;

  // Generator bookkeeping.
  int gen_fill, gen_cap, n_ops;
  bit idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_queue_with_max_core u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .value_in(value_in),
    .done(done),
    .status(status),
    .value_out(value_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity(capacity)
  );

  function automatic logic [5:0] step_slot(input logic [5:0] i);
    int n;
    n = int'(i) + 1;
    if (n >= int'(cap_m) || n >= DEPTH) return 6'd0;
    return 6'(n);
  endfunction

  function automatic void rescan_runner_up();
    logic [5:0] i;
    int guard;
    i = step_slot(max_slot_m);
    guard = 0;
    run_ok_m = 1'b0;
    run_val_m = bqm_pkg::MOST_NEG;
    run_slot_m = '0;
    while (i != tail_m && guard < DEPTH) begin
      if (!run_ok_m || mem_m[i] > run_val_m) begin
        run_ok_m = 1'b1;
        run_val_m = mem_m[i];
        run_slot_m = i;
      end
      i = step_slot(i);
      guard++;
    end
  endfunction

  function automatic void clear_runner_up();
    run_ok_m = 1'b0;
    run_val_m = bqm_pkg::MOST_NEG;
    run_slot_m = '0;
  endfunction

  function automatic resp_t predict_queue_op(input logic [bqm_pkg::OP_W-1:0] op,
                                             input logic signed [bqm_pkg::DATA_W-1:0] v);
    resp_t r;
    logic [5:0] s;
    r.status = bqm_pkg::STATUS_OK;
    r.value = '0;
    case (op)
      bqm_pkg::OP_ENQUEUE: begin
        if (fill_m >= cap_m) begin
          r.status = bqm_pkg::STATUS_FULL;
        end else begin
          s = tail_m;
          if (fill_m == 0 || v > max_val_m) begin
            max_val_m = v;
            max_slot_m = s;
            clear_runner_up();
          end else if (!run_ok_m || v > run_val_m) begin
            run_ok_m = 1'b1;
            run_val_m = v;
            run_slot_m = s;
          end
          mem_m[s] = v;
          tail_m = step_slot(s);
          fill_m++;
        end
      end
      bqm_pkg::OP_DEQUEUE: begin
        if (fill_m == 0) begin
          r.status = bqm_pkg::STATUS_EMPTY;
        end else begin
          s = head_m;
          r.value = mem_m[s];
          head_m = step_slot(s);
          fill_m--;
          if (s == max_slot_m) begin
            if (run_ok_m && fill_m != 0) begin
              max_val_m = run_val_m;
              max_slot_m = run_slot_m;
              rescan_runner_up();
            end else begin
              max_val_m = bqm_pkg::MOST_NEG;
              max_slot_m = '0;
              clear_runner_up();
            end
          end
        end
      end
      bqm_pkg::OP_QUERY: begin
        if (fill_m == 0) r.status = bqm_pkg::STATUS_EMPTY;
        else r.value = max_val_m;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void apply_capacity(input logic [bqm_pkg::CAP_W-1:0] v);
    logic [bqm_pkg::CAP_W-1:0] nv;
    if (fill_m != 0) return;
    nv = v;
    if (nv == 0) nv = 1;
    if (int'(nv) > DEPTH) nv = bqm_pkg::CAP_W'(DEPTH);
    cap_m = nv;
    head_m = '0;
    tail_m = '0;
    run_ok_m = 1'b0;
  endfunction

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  function automatic logic signed [bqm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return bqm_pkg::DATA_W'($signed($urandom_range(0, 16)) - 8);
      5: begin
        case ($urandom_range(0, 3))
          0: return bqm_pkg::MOST_NEG;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic [bqm_pkg::OP_W-1:0] op,
                         input logic signed [bqm_pkg::DATA_W-1:0] v);
    req_t r;
    r.kind = REQ_OP;
    r.op = op;
    r.val = v;
    r.cap = '0;
    r.gap = pick_gap();
    req_q.push_back(r);
    n_ops++;
    if (op == bqm_pkg::OP_ENQUEUE && gen_fill < gen_cap) gen_fill++;
    else if (op == bqm_pkg::OP_DEQUEUE && gen_fill > 0) gen_fill--;
  endtask

  task automatic push_hold();
    req_t r;
    r.kind = REQ_HOLD;
    r.op = '0;
    r.val = '0;
    r.cap = '0;
    r.gap = 0;
    req_q.push_back(r);
  endtask

  // The capacity is only rewritten on an empty queue, so drain first.
  task automatic push_capacity(input logic [bqm_pkg::CAP_W-1:0] v);
    req_t r;
    while (gen_fill > 0) push_op(bqm_pkg::OP_DEQUEUE, $urandom);
    r.kind = REQ_CFG;
    r.op = '0;
    r.val = '0;
    r.cap = v;
    r.gap = 0;
    req_q.push_back(r);
    gen_cap = (v == 0) ? 1 : ((int'(v) > DEPTH) ? DEPTH : int'(v));
  endtask

  // Driver.
  logic d_start, d_cfg;
  logic [bqm_pkg::OP_W-1:0] d_op;
  logic signed [bqm_pkg::DATA_W-1:0] d_val;
  logic [bqm_pkg::CAP_W-1:0] d_cap;
  int gap_left = 0;
  int quiet = 0;
  req_t cur;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      quiet = 0;
    end else begin
      d_start = start;
      d_cfg = cfg_valid;
      d_op = opcode;
      d_val = value_in;
      d_cap = capacity;
      if (start && !busy) d_start = 1'b0;
      if (cfg_valid && cfg_ready) d_cfg = 1'b0;
      if (!start && !cfg_valid && !busy && expected_resp.size() == 0) quiet++;
      else quiet = 0;
      if (!d_start && !d_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          case (req_q[0].kind)
            REQ_OP: begin
              cur = req_q.pop_front();
              d_start = 1'b1;
              d_op = cur.op;
              d_val = cur.val;
              gap_left = cur.gap;
            end
            REQ_CFG: begin
              if (quiet >= SETTLE_CYCLES) begin
                cur = req_q.pop_front();
                d_cfg = 1'b1;
                d_cap = cur.cap;
              end
            end
            default: begin
              if (quiet >= 1) cur = req_q.pop_front();
            end
          endcase
        end
      end
      start <= d_start;
      cfg_valid <= d_cfg;
      opcode <= d_op;
      value_in <= d_val;
      capacity <= d_cap;
    end
  end

  // Monitor: check completed items, then predict newly accepted ones.
  resp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_resp.size() == 0) begin
          $display("%0t unexpected result: expected none, got status %0d value %0d",
                   $time, status, value_out);
          errors++;
        end else begin
          want = expected_resp.pop_front();
          if (status !== want.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, status);
            errors++;
          end
          if (value_out !== want.value) begin
            $display("%0t value_out mismatch: expected %0d, got %0d",
                     $time, want.value, value_out);
            errors++;
          end
        end
      end
      if (start && !busy) expected_resp.push_back(predict_queue_op(opcode, value_in));
      if (cfg_valid && cfg_ready) apply_capacity(capacity);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int len, roll, enq_bias, k, c;
    logic [bqm_pkg::CAP_W-1:0] cap_v;
    head_m = '0;
    tail_m = '0;
    fill_m = '0;
    cap_m = bqm_pkg::CAP_W'((DEPTH < bqm_pkg::CAP_RESET) ? DEPTH : bqm_pkg::CAP_RESET);
    max_val_m = bqm_pkg::MOST_NEG;
    max_slot_m = '0;
    clear_runner_up();
    for (int i = 0; i < DEPTH; i++) mem_m[i] = '0;
    gen_fill = 0;
    gen_cap = int'(cap_m);
    n_ops = 0;
    idle_on = 1'b1;
    enq_bias = 50;

    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_DEQUEUE, 32'sh7FFF_FFFF);
    push_op(OP_UNUSED, -32'sd1);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sd5);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sd5);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sd3);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_DEQUEUE, '0);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_DEQUEUE, '0);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_DEQUEUE, '0);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_ENQUEUE, bqm_pkg::MOST_NEG);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sh7FFF_FFFF);
    push_op(bqm_pkg::OP_ENQUEUE, -32'sd1);
    push_op(bqm_pkg::OP_ENQUEUE, -32'sd2000000000);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_hold();
    push_capacity(7'd0);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sd7);
    push_op(bqm_pkg::OP_ENQUEUE, 32'sd8);
    push_op(bqm_pkg::OP_QUERY, '0);
    push_op(bqm_pkg::OP_DEQUEUE, '0);
    push_capacity(7'd127);

    while (n_ops < RANDOM_OPS) begin
      idle_on = ($urandom_range(0, 3) != 0) && (n_ops < RANDOM_OPS - 75);
      c = $urandom_range(0, 9);
      case (c)
        0, 1, 2, 3: cap_v = bqm_pkg::CAP_W'($urandom_range(1, 8));
        4, 5: cap_v = bqm_pkg::CAP_W'($urandom_range(9, 64));
        6: cap_v = 7'd0;
        7: cap_v = bqm_pkg::CAP_W'($urandom_range(65, 127));
        8: cap_v = 7'd1;
        default: cap_v = 7'd64;
      endcase
      push_capacity(cap_v);
      len = $urandom_range(30, 90);
      for (k = 0; k < len && n_ops < RANDOM_OPS; k++) begin
        if (n_ops >= RANDOM_OPS - 75) idle_on = 1'b0;
        if (k % 16 == 0) enq_bias = $urandom_range(20, 90);
        roll = $urandom_range(0, 99);
        if (roll < 3) push_op(OP_UNUSED, $urandom);
        else if (roll < 15) push_op(bqm_pkg::OP_QUERY, $urandom);
        else if ($urandom_range(0, 99) < enq_bias) push_op(bqm_pkg::OP_ENQUEUE, pick_value());
        else push_op(bqm_pkg::OP_DEQUEUE, $urandom);
        if ($urandom_range(0, 149) == 0) push_hold();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (req_q.size() != 0 || start || cfg_valid || expected_resp.size() != 0 || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_resp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
